/* hw/rtl/stki_pkg.sv */
// ----------------------------------------------------------------------------
// stki_pkg
// Shared sizes, types and control structs for the streaming top-k block.
// ----------------------------------------------------------------------------
package stki_pkg;

    localparam int MAX_KEEP   = 16;
    localparam int SCORE_W    = 32;
    localparam int KEEP_W     = 5;
    localparam int CNT_W      = $clog2(MAX_KEEP + 1);
    localparam int RANK_W     = 4;
    localparam int OUT_DATA_W = ((SCORE_W + RANK_W + 7) / 8) * 8;
    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

    typedef logic signed [SCORE_W-1:0] t_score;

    typedef enum logic {
        ST_COLLECT,
        ST_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic final_entry;
    } t_status;

endpackage

/* hw/rtl/streaming_top_k_insertion.sv */
// ----------------------------------------------------------------------------
// streaming_top_k_insertion
// Keeps the k largest signed scores of a vector and emits them sorted.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one signed 32-bit score per request in tdata, tlast marks
//   the final score of a vector. Each score is placed into a sorted list in
//   the cycle it is taken (a later equal score goes behind an earlier one);
//   the input accepts one score per cycle while a vector is collected.
//   On the score with tlast the block stops taking input and, from the next
//   cycle, emits the list largest first on the master stream: tdata carries
//   the score and its rank, tlast the final entry. One entry leaves per cycle
//   while tready is high; the input is stalled while the list drains and
//   while the receiver holds tready low. The list then clears and input
//   resumes. The config channel writes k (keep count, 0 acts as 1, above 16
//   as 16); it is always ready and k resets to 16. Reset empties the list.
// ----------------------------------------------------------------------------
module streaming_top_k_insertion
    import stki_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [SCORE_W-1:0]    i_s_axis_tdata,   // [31:0] score
    input  logic                  i_s_axis_tlast,   // end_of_vector
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // [31:0] top_score, [35:32] rank
    output logic                  o_m_axis_tlast,   // last_of_list
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [KEEP_W-1:0]     i_cfg_data        // keep_count
);

    t_cmd              cmd;
    t_status           status;
    t_score            head;
    logic [RANK_W-1:0] rank;

    stki_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_last   (i_s_axis_tlast),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    stki_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_score    (t_score'(i_s_axis_tdata)),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_keep (i_cfg_data),
        .o_head     (head),
        .o_rank     (rank)
    );

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {(OUT_DATA_W - SCORE_W - RANK_W)'(0), rank, head};
    assign o_m_axis_tlast = status.final_entry;

endmodule

/* hw/rtl/stki_dp.sv */
// ----------------------------------------------------------------------------
// stki_dp
// Sorted score list with parallel-compare insertion and shift-out emission.
// ----------------------------------------------------------------------------
module stki_dp
    import stki_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  t_score              i_score,
    input  logic                i_cfg_we,
    input  logic [KEEP_W-1:0]   i_cfg_keep,
    output t_score              o_head,
    output logic [RANK_W-1:0]   o_rank
);

    t_score                 r_list [MAX_KEEP];
    t_score                 n_list [MAX_KEEP];
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic [RANK_W-1:0]      r_rank;
    logic [KEEP_W-1:0]      r_keep;

    logic [CNT_W-1:0]       k_eff;
    logic [CNT_W-1:0]       cnt_cut;
    logic [MAX_KEEP-1:0]    ge;
    logic [MAX_KEEP-1:0]    k_mask;
    logic                   ins_ok;

    always_comb begin
        if (r_keep == '0) begin
            k_eff = CNT_W'(1);
        end else if (CNT_W'(r_keep) > CNT_W'(MAX_KEEP)) begin
            k_eff = CNT_W'(MAX_KEEP);
        end else begin
            k_eff = CNT_W'(r_keep);
        end
        cnt_cut = (r_cnt > k_eff) ? k_eff : r_cnt;
        k_mask  = MAX_KEEP'(1) << (k_eff - CNT_W'(1));
        // entries at or above the new score form a prefix of the list
        for (int i = 0; i < MAX_KEEP; i++) begin
            ge[i] = (CNT_W'(i) < cnt_cut) && (r_list[i] >= i_score);
        end
        ins_ok = ~|(ge & k_mask);
    end

    always_comb begin
        n_list = r_list;
        n_cnt  = r_cnt;
        if (i_cmd.insert) begin
            n_cnt = cnt_cut;
            if (ins_ok) begin
                if (ge[0]) begin
                    n_list[0] = r_list[0];
                end else begin
                    n_list[0] = i_score;
                end
                for (int i = 1; i < MAX_KEEP; i++) begin
                    if (ge[i]) begin
                        n_list[i] = r_list[i];
                    end else if (ge[i-1]) begin
                        n_list[i] = i_score;
                    end else begin
                        n_list[i] = r_list[i-1];
                    end
                end
                n_cnt = (cnt_cut < k_eff) ? cnt_cut + CNT_W'(1) : k_eff;
            end
        end else if (i_cmd.shift) begin
            // advance the list toward the head
            for (int i = 0; i < MAX_KEEP - 1; i++) begin
                n_list[i] = r_list[i+1];
            end
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_list <= n_list;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_rank <= '0;
            r_keep <= KEEP_RESET;
        end else begin
            r_cnt <= n_cnt;
            if (i_cmd.insert) begin
                r_rank <= '0;
            end else if (i_cmd.shift) begin
                r_rank <= r_rank + RANK_W'(1);
            end
            if (i_cfg_we) begin
                r_keep <= i_cfg_keep;
            end
        end
    end

    assign o_status.final_entry = (r_cnt == CNT_W'(1));
    assign o_head               = r_list[0];
    assign o_rank               = r_rank;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_KEEP))
        else $error("kept count above list depth");

    a_insert_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> r_cnt != '0)
        else $error("list empty after insertion");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift && r_cnt == CNT_W'(1)) |=> r_cnt == '0)
        else $error("list not cleared after final entry");

endmodule

/* hw/rtl/stki_ctrl.sv */
// ----------------------------------------------------------------------------
// stki_ctrl
// Controller: collects scores, then drains the sorted list on a frame end.
// ----------------------------------------------------------------------------
module stki_ctrl
    import stki_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        o_cmd.insert = 1'b0;
        o_cmd.shift  = 1'b0;
        case (r_state)
            ST_COLLECT: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.insert = 1'b1;
                    if (i_in_last) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.final_entry) begin
                        n_state = ST_COLLECT;
                    end
                end
            end
            default: begin
                n_state = ST_COLLECT;
            end
        endcase
    end

    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output active together");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && i_status.final_entry) |=> !o_out_valid)
        else $error("output still valid after final entry");

endmodule

/* test/streaming_top_k_insertion_tb.sv */
// ----------------------------------------------------------------------------
// streaming_top_k_insertion_tb
// Drives score vectors into the top-k block and checks every emitted entry
// against a sorted-insertion predictor kept in step with the accepted scores.
// The keep count is rewritten between phases, also while a vector is open.
// ----------------------------------------------------------------------------
module streaming_top_k_insertion_tb;
    import stki_pkg::*;

    typedef struct {
        t_score score;
        logic   eov;
    } t_score_item;

    typedef struct {
        t_score              score;
        logic [RANK_W-1:0]   rank;
        logic                last;
    } t_ranked_entry;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [SCORE_W-1:0]    i_s_axis_tdata = '0;   // [31:0] score
    logic                  i_s_axis_tlast = 1'b0; // end_of_vector
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;        // [31:0] top_score, [35:32] rank
    logic                  o_m_axis_tlast;        // last_of_list
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [KEEP_W-1:0]     i_cfg_data = '0;       // keep_count

    t_score_item   queued_scores[$];
    t_ranked_entry expected_ranking[$];

    // predictor state
    t_score            kept_list[MAX_KEEP];
    int                kept_len = 0;
    logic [KEEP_W-1:0] keep_k = KEEP_RESET;

    int   errors = 0;
    int   gap_pct = 12;
    logic in_fire = 1'b0;

    streaming_top_k_insertion u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic note_mismatch(input string what);
        if (errors < 20) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
        errors++;
    endtask

    // Place a score behind every kept score >= it; drop it past position k.
    function automatic void insert_ranked(input t_score s);
        int k;
        int pos;
        int last;
        int i;
        k = (keep_k == 0) ? 1 : ((keep_k > MAX_KEEP) ? MAX_KEEP : int'(keep_k));
        if (kept_len > k) kept_len = k;
        pos = 0;
        while (pos < kept_len && kept_list[pos] >= s) pos++;
        if (pos >= k) return;
        last = (kept_len < k) ? kept_len : k - 1;
        for (i = last; i > pos; i--) kept_list[i] = kept_list[i - 1];
        kept_list[pos] = s;
        if (kept_len < k) kept_len++;
    endfunction

    function automatic void emit_ranking();
        t_ranked_entry e;
        int i;
        for (i = 0; i < kept_len; i++) begin
            e.score = kept_list[i];
            e.rank  = RANK_W'(i);
            e.last  = (i == kept_len - 1);
            expected_ranking.push_back(e);
        end
        kept_len = 0;
    endfunction

    // Sample both streams at the rising edge: predict on accept, check on emit.
    always @(posedge i_clk) begin : monitor
        t_ranked_entry e;
        in_fire = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (in_fire) begin
            insert_ranked(t_score'(i_s_axis_tdata));
            if (i_s_axis_tlast) emit_ranking();
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_ranking.size() == 0) begin
                note_mismatch($sformatf("unexpected entry score=%0d",
                                        $signed(o_m_axis_tdata[SCORE_W-1:0])));
            end else begin
                e = expected_ranking.pop_front();
                if (o_m_axis_tdata[SCORE_W-1:0] !== e.score)
                    note_mismatch($sformatf("score %0d, want %0d",
                                            $signed(o_m_axis_tdata[SCORE_W-1:0]), e.score));
                if (o_m_axis_tdata[SCORE_W+RANK_W-1:SCORE_W] !== e.rank)
                    note_mismatch($sformatf("rank %0d, want %0d",
                                            o_m_axis_tdata[SCORE_W+RANK_W-1:SCORE_W], e.rank));
                if (o_m_axis_tlast !== e.last)
                    note_mismatch($sformatf("last %b, want %b", o_m_axis_tlast, e.last));
            end
        end
    end

    // Advance the input request once the current one is taken.
    always @(negedge i_clk) begin : driver
        t_score_item item;
        if (i_rst_n && (!i_s_axis_tvalid || in_fire)) begin
            if (queued_scores.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
                item = queued_scores.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= item.score;
                i_s_axis_tlast  <= item.eov;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= gap_pct);
    end

    task automatic queue_score(input t_score s, input logic eov);
        t_score_item item;
        item.score = s;
        item.eov   = eov;
        queued_scores.push_back(item);
    endtask

    // Hold until every request is taken and every entry has left.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (queued_scores.size() != 0 || i_s_axis_tvalid || expected_ranking.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_keep(input logic [KEEP_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        keep_k = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_score pick_score();
        case ($urandom_range(0, 9))
            0: return t_score'(32'h8000_0000);
            1: return t_score'(32'h7FFF_FFFF);
            2: return t_score'($urandom_range(0, 1) ? -1 : 0);
            3, 4, 5: return t_score'(int'($urandom_range(0, 16)) - 8);
            default: return t_score'($urandom);
        endcase
    endfunction

    function automatic logic [KEEP_W-1:0] pick_keep();
        case ($urandom_range(0, 5))
            0: return KEEP_W'(0);
            1: return KEEP_W'(1);
            2: return KEEP_W'(16);
            3: return KEEP_W'(31);
            4: return KEEP_W'($urandom_range(17, 30));
            default: return KEEP_W'($urandom_range(2, 15));
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int budget;
        int vec_left;
        int phase;
        int j;
        sent = 0;
        vec_left = 0;
        phase = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single minimum score, then extremes and ties at the reset keep count
        queue_score(t_score'(32'h8000_0000), 1'b1);
        queue_score(t_score'(32'h7FFF_FFFF), 1'b0);
        queue_score(-1, 1'b0);
        queue_score(0, 1'b0);
        queue_score(1, 1'b0);
        queue_score(t_score'(32'h8000_0000), 1'b0);
        queue_score(5, 1'b0);
        queue_score(5, 1'b0);
        queue_score(t_score'(32'h7FFF_FFFF), 1'b1);
        wait_drained();

        // zero keep count acts as one
        write_keep(KEEP_W'(0));
        queue_score(3, 1'b0);
        queue_score(7, 1'b0);
        queue_score(-2, 1'b1);
        wait_drained();

        // oversized keep count, then lower it with a vector half collected
        write_keep(KEEP_W'(31));
        queue_score(10, 1'b0);
        queue_score(-10, 1'b0);
        queue_score(10, 1'b0);
        queue_score(t_score'(32'h7FFF_FFFF), 1'b0);
        queue_score(t_score'(32'h8000_0000), 1'b0);
        queue_score(0, 1'b0);
        wait_drained();
        write_keep(KEEP_W'(2));
        queue_score(4, 1'b0);
        queue_score(20, 1'b1);
        wait_drained();

        while (sent < 330) begin
            write_keep(pick_keep());
            gap_pct = (phase == 2) ? 0 : 12;
            budget = $urandom_range(30, 60);
            for (j = 0; j < budget; j++) begin
                if (vec_left == 0)
                    vec_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 22);
                vec_left--;
                queue_score(pick_score(), vec_left == 0);
                sent++;
            end
            wait_drained();
            phase++;
        end
        gap_pct = 12;
        while (vec_left != 0) begin
            vec_left--;
            queue_score(pick_score(), vec_left == 0);
        end
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(2_400_000);
        $display("status: fail");
        $finish;
    end

endmodule
